// ===== hdl/pcad_pkg.sv =====
package pcad_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 8;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_MIN   = 2'd1;
    localparam logic [1:0] KIND_MAX   = 2'd2;

    localparam logic [2:0] COL_RGBA   = 3'd0;
    localparam logic [2:0] COL_RGB    = 3'd1;
    localparam logic [2:0] COL_565    = 3'd2;
    localparam logic [2:0] COL_CONST  = 3'd3;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_OFF_X  = 3'd1;
    localparam logic [2:0] REG_OFF_Y  = 3'd2;
    localparam logic [2:0] REG_OFF_Z  = 3'd3;
    localparam logic [2:0] REG_SCL_X  = 3'd4;
    localparam logic [2:0] REG_SCL_Y  = 3'd5;
    localparam logic [2:0] REG_SCL_Z  = 3'd6;
    localparam logic [2:0] REG_CCOL   = 3'd7;

    localparam logic [30:0] SCALE_RESET  = 31'd65536;
    localparam logic [31:0] BOX_MIN_INIT = 32'h7FFF_FFFF;
    localparam logic [31:0] BOX_MAX_INIT = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic        [31:0] colour_word;
        logic               last_point;
    } t_in;

    typedef struct packed {
        logic        [1:0]  kind;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic        [7:0]  red;
        logic        [7:0]  green;
        logic        [7:0]  blue;
        logic        [7:0]  alpha;
        logic               run_end;
    } t_out;

    typedef struct packed {
        logic [3:0]       mode;
        logic [2:0][31:0] offset;
        logic [2:0][30:0] scale;
        logic [31:0]      const_colour;
    } t_cfg;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [31:0]      colour;
        logic             last;
    } t_point;

endpackage

// ===== hdl/pcad_front.sv =====
module pcad_front import pcad_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_in    i_item,
    input  t_cfg   i_cfg,
    output logic   o_valid,
    output t_point o_point
);

    localparam int unsigned NS = 4;

    logic [NS-1:0] r_v;
    t_point        r_side [NS];
    logic [46:0]   r_prod [3];
    logic [46:0]   r_x2   [3];
    logic [46:0]   r_x3   [3];
    logic [31:0]   r_qe   [3];
    logic [31:0]   r_term [3];
    logic [2:0][31:0] n_pos;
    logic [2:0][31:0] raw_in;
    logic [31:0]   col;
    logic [31:0]   w;
    logic          r_out_v;
    t_point        r_out;

    assign raw_in = {i_item.coord_z, i_item.coord_y, i_item.coord_x};
    assign w      = i_item.colour_word;

    always_comb begin
        unique case (i_cfg.mode[2:0])
            COL_RGBA:  col = w;
            COL_RGB:   col = {8'hFF, w[23:0]};
            COL_565:   col = {8'hFF, w[4:0], w[4:2], w[10:5], w[10:9], w[15:11], w[15:13]};
            COL_CONST: col = i_cfg.const_colour;
            default:   col = '1;
        endcase
    end

    genvar a;
    generate
        for (a = 0; a < 3; a++) begin : g_axis
            logic [47:0] est;
            logic [17:0] rem;
            logic [33:0] sum;

            assign est = {1'b0, r_x2[a]} + {17'b0, r_x2[a][46:16]} + {33'b0, r_x2[a][46:32]};
            assign rem = r_x3[a][17:0] + r_qe[a][17:0] - {r_qe[a][1:0], 16'h0000};
            assign sum = {{2{i_cfg.offset[a][31]}}, i_cfg.offset[a]} + {2'b00, r_term[a]};

            always_ff @(posedge i_clk) begin
                r_prod[a] <= {31'b0, raw_in[a][15:0]} * {16'b0, i_cfg.scale[a]};
                r_x2[a]   <= r_prod[a] + 47'd32767;
                r_x3[a]   <= r_x2[a];
                r_qe[a]   <= est[47:16];
                r_term[a] <= r_qe[a] + {31'b0, (rem >= 18'd65535)};
            end

            always_comb begin
                if (!i_cfg.mode[3]) begin
                    n_pos[a] = r_side[NS-1].pos[a];
                end else if (!sum[33] && (sum[32:31] != 2'b00)) begin
                    n_pos[a] = BOX_MIN_INIT;
                end else if (sum[33] && (sum[32:31] != 2'b11)) begin
                    n_pos[a] = BOX_MAX_INIT;
                end else begin
                    n_pos[a] = sum[31:0];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_v     <= {r_v[NS-2:0], i_valid};
            r_out_v <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0].pos    <= raw_in;
        r_side[0].colour <= col;
        r_side[0].last   <= i_item.last_point;
        for (int s = 1; s < NS; s++) begin
            r_side[s] <= r_side[s-1];
        end
        r_out.pos    <= n_pos;
        r_out.colour <= r_side[NS-1].colour;
        r_out.last   <= r_side[NS-1].last;
    end

    assign o_valid = r_out_v;
    assign o_point = r_out;

endmodule

// ===== hdl/pcad_fifo.sv =====
module pcad_fifo import pcad_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_point i_wdata,
    input  logic   i_rd,
    output logic   o_valid,
    output t_point o_rdata
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_point           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_rd) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_wr) - CNT_W'(i_rd);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && !i_rd && (r_count == CNT_W'(DEPTH))))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && (r_count == '0)))
        else $error("queue read while empty");

endmodule

// ===== hdl/pcad_back.sv =====
module pcad_back import pcad_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    input  t_point i_q_data,
    output logic   o_q_rd,
    input  logic   i_pop,
    output logic   o_empty,
    output t_out   o_result
);

    typedef enum logic [2:0] {
        ST_PT  = 3'b001,
        ST_MIN = 3'b010,
        ST_MAX = 3'b100
    } t_bstate;

    t_bstate          r_state, n_state;
    logic [2:0][31:0] r_min, n_min;
    logic [2:0][31:0] r_max, n_max;
    logic [2:0][31:0] upd_min, upd_max;
    logic             r_out_v, n_out_v;
    t_out             r_out, n_out;
    logic             load;

    assign load = !r_out_v || i_pop;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            upd_min[a] = ($signed(i_q_data.pos[a]) < $signed(r_min[a])) ? i_q_data.pos[a]
                                                                         : r_min[a];
            upd_max[a] = ($signed(i_q_data.pos[a]) > $signed(r_max[a])) ? i_q_data.pos[a]
                                                                         : r_max[a];
        end
    end

    always_comb begin
        n_state = r_state;
        n_min   = r_min;
        n_max   = r_max;
        n_out_v = r_out_v && !i_pop;
        n_out   = r_out;
        o_q_rd  = 1'b0;
        unique case (r_state)
            ST_PT: begin
                if (i_q_valid && load) begin
                    o_q_rd        = 1'b1;
                    n_min         = upd_min;
                    n_max         = upd_max;
                    n_out_v       = 1'b1;
                    n_out.kind    = KIND_POINT;
                    n_out.out_x   = i_q_data.pos[0];
                    n_out.out_y   = i_q_data.pos[1];
                    n_out.out_z   = i_q_data.pos[2];
                    n_out.red     = i_q_data.colour[7:0];
                    n_out.green   = i_q_data.colour[15:8];
                    n_out.blue    = i_q_data.colour[23:16];
                    n_out.alpha   = i_q_data.colour[31:24];
                    n_out.run_end = !i_q_data.last;
                    if (i_q_data.last) begin
                        n_state = ST_MIN;
                    end
                end
            end
            ST_MIN: begin
                if (load) begin
                    n_out_v       = 1'b1;
                    n_out         = '0;
                    n_out.kind    = KIND_MIN;
                    n_out.out_x   = r_min[0];
                    n_out.out_y   = r_min[1];
                    n_out.out_z   = r_min[2];
                    n_state       = ST_MAX;
                end
            end
            ST_MAX: begin
                if (load) begin
                    n_out_v       = 1'b1;
                    n_out         = '0;
                    n_out.kind    = KIND_MAX;
                    n_out.out_x   = r_max[0];
                    n_out.out_y   = r_max[1];
                    n_out.out_z   = r_max[2];
                    n_out.run_end = 1'b1;
                    n_min         = {3{BOX_MIN_INIT}};
                    n_max         = {3{BOX_MAX_INIT}};
                    n_state       = ST_PT;
                end
            end
            default: begin
                n_state = ST_PT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PT;
            r_min   <= {3{BOX_MIN_INIT}};
            r_max   <= {3{BOX_MAX_INIT}};
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_min   <= n_min;
            r_max   <= n_max;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_empty  = !r_out_v;
    assign o_result = r_out;

    a_no_pop_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_PT) |-> !o_q_rd)
        else $error("queue popped while box results pending");

    a_box_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_MAX) && load) |=>
            ((r_state == ST_PT) && (r_min == {3{BOX_MIN_INIT}})
             && (r_max == {3{BOX_MAX_INIT}})))
        else $error("box not cleared after maximum result");

endmodule

// ===== hdl/point_cloud_attribute_decoder_core.sv =====
// Channel   Direction  Handshake                 Payload
// point     in         push / full               i_point  (t_in)
// result    out        empty / pop               o_result (t_out)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One point per cycle sustained while full is low; a point result passes through the
// 5-stage dequantize pipeline, the queue and the output register before it leaves.
// The last point of a cloud holds the back end while it emits the box corners.
// full rises when QUEUE_DEPTH requests are in flight or queued; QUEUE_DEPTH must exceed 6.
// Synchronous active-low reset empties the pipeline and queue and clears the box.
module point_cloud_attribute_decoder_core import pcad_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in         i_point,
    output logic        empty,
    input  logic        pop,
    output t_out        o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned USED_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg              r_cfg;
    logic [USED_W-1:0] r_used;
    logic              accept;
    logic              f_valid;
    t_point            f_point;
    logic              q_valid;
    t_point            q_data;
    logic              q_rd;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;
    assign full        = (r_used == USED_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= '0;
            r_cfg.offset       <= '0;
            r_cfg.scale        <= {3{SCALE_RESET}};
            r_cfg.const_colour <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:  r_cfg.mode         <= i_cfg_data[3:0];
                REG_OFF_X: r_cfg.offset[0]    <= i_cfg_data;
                REG_OFF_Y: r_cfg.offset[1]    <= i_cfg_data;
                REG_OFF_Z: r_cfg.offset[2]    <= i_cfg_data;
                REG_SCL_X: r_cfg.scale[0]     <= i_cfg_data[30:0];
                REG_SCL_Y: r_cfg.scale[1]     <= i_cfg_data[30:0];
                REG_SCL_Z: r_cfg.scale[2]     <= i_cfg_data[30:0];
                REG_CCOL:  r_cfg.const_colour <= i_cfg_data;
                default:   r_cfg.mode         <= r_cfg.mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= r_used + USED_W'(accept) - USED_W'(q_rd);
        end
    end

    pcad_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_point),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .o_point (f_point)
    );

    pcad_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_wdata (f_point),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_rdata (q_data)
    );

    pcad_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

// ===== bench/point_cloud_attribute_decoder_core_tb.sv =====
module point_cloud_attribute_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcad_pkg::*;

    localparam logic [2:0] COL_WHITE        = 3'd4;
    localparam logic [2:0] COL_WHITE_TOP    = 3'd7;
    localparam logic [3:0] QUANT_FLAG       = 4'b1000;
    localparam int         SETTLE_CYCLES    = 12;
    localparam int         PHASES           = 13;
    localparam int         POINTS_PER_PHASE = 28;
    localparam int         HOLD_OFF_CYCLES  = 60;

    typedef struct {
        bit          is_write;
        logic [2:0]  idx;
        logic [31:0] data;
        t_in         pt;
        bit          fixed;
        t_out        want;
    } t_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    t_in         i_point     = '0;
    logic        empty;
    logic        pop         = 1'b0;
    t_out        o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;

    logic [3:0]         cfg_mode;
    logic signed [31:0] cfg_offset [3];
    logic [30:0]        cfg_scale [3];
    logic [31:0]        cfg_colour;
    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    t_out               decoded_q [$];
    t_row               script [$];

    int errors         = 0;
    int points_sent    = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int stall_left     = 0;
    bit calm_source    = 1'b0;
    bit calm_sink      = 1'b0;
    bit hold_off_req   = 1'b0;

    point_cloud_attribute_decoder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_point     (i_point),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #10_000_000;
        $display("point_cloud_attribute_decoder_core_tb: errors");
        $finish;
    end

    function automatic logic signed [31:0] dequantize(input logic [31:0] raw, input int axis);
        longint term;
        longint sum;
        term = (longint'(raw[15:0]) * longint'(cfg_scale[axis]) + 64'sd32767) / 64'sd65535;
        sum  = longint'(cfg_offset[axis]) + term;
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
        end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
        end
        return sum[31:0];
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx) inside
            REG_MODE:                       cfg_mode = data[3:0];
            REG_OFF_X, REG_OFF_Y, REG_OFF_Z: cfg_offset[idx - REG_OFF_X] = data;
            REG_SCL_X, REG_SCL_Y, REG_SCL_Z: cfg_scale[idx - REG_SCL_X] = data[30:0];
            REG_CCOL:                       cfg_colour = data;
            default: ;
        endcase
    endfunction

    function automatic void stash_result(input t_out res);
        decoded_q.insert(decoded_q.size(), res);
    endfunction

    function automatic void decode_point(input t_in p);
        logic [31:0]        raw [3];
        logic signed [31:0] pos [3];
        logic [31:0]        w;
        t_out               res;
        int                 i;
        raw[0] = p.coord_x;
        raw[1] = p.coord_y;
        raw[2] = p.coord_z;
        for (i = 0; i < 3; i++) begin
            pos[i] = cfg_mode[3] ? dequantize(raw[i], i) : raw[i];
            if (pos[i] < box_lo[i]) box_lo[i] = pos[i];
            if (pos[i] > box_hi[i]) box_hi[i] = pos[i];
        end
        res = '0;
        w   = p.colour_word;
        case (cfg_mode[2:0])
            COL_RGBA: begin
                {res.alpha, res.blue, res.green, res.red} = w;
            end
            COL_RGB: begin
                {res.blue, res.green, res.red} = w[23:0];
                res.alpha = 8'hFF;
            end
            COL_565: begin
                res.red   = {w[15:11], w[15:13]};
                res.green = {w[10:5], w[10:9]};
                res.blue  = {w[4:0], w[4:2]};
                res.alpha = 8'hFF;
            end
            COL_CONST: begin
                {res.alpha, res.blue, res.green, res.red} = cfg_colour;
            end
            default: begin
                {res.alpha, res.blue, res.green, res.red} = 32'hFFFF_FFFF;
            end
        endcase
        res.kind    = KIND_POINT;
        res.out_x   = pos[0];
        res.out_y   = pos[1];
        res.out_z   = pos[2];
        res.run_end = !p.last_point;
        stash_result(res);
        if (p.last_point) begin
            res       = '0;
            res.kind  = KIND_MIN;
            res.out_x = box_lo[0];
            res.out_y = box_lo[1];
            res.out_z = box_lo[2];
            stash_result(res);
            res.kind    = KIND_MAX;
            res.out_x   = box_hi[0];
            res.out_y   = box_hi[1];
            res.out_z   = box_hi[2];
            res.run_end = 1'b1;
            stash_result(res);
            for (i = 0; i < 3; i++) begin
                box_lo[i] = BOX_MIN_INIT;
                box_hi[i] = BOX_MAX_INIT;
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (decoded_q.size() == 0) begin
                $error("result of kind %0d arrived with nothing outstanding", o_result.kind);
                errors++;
            end else begin
                want = decoded_q.pop_front();
                check_field("kind", want.kind, o_result.kind);
                check_field("out_x", want.out_x, o_result.out_x);
                check_field("out_y", want.out_y, o_result.out_y);
                check_field("out_z", want.out_z, o_result.out_z);
                check_field("red", want.red, o_result.red);
                check_field("green", want.green, o_result.green);
                check_field("blue", want.blue, o_result.blue);
                check_field("alpha", want.alpha, o_result.alpha);
                check_field("run_end", want.run_end, o_result.run_end);
            end
        end
    end

    // drive pop randomly or steadily high, and hold pop low on request so the queue backs up and stalls the sender
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if (calm_sink) begin
            pop <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                pop <= 1'b1;
            end else begin
                pop <= 1'b0;
                stall_left = (r < 94) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
        end
    end

    task automatic offer_point(input t_in p, input bit fixed, input t_out want);
        int r;
        int gap;
        i_point <= p;
        push    <= 1'b1;
        do @(posedge i_clk); while (full);
        decode_point(p);
        if (fixed) decoded_q[decoded_q.size() - 1] = want;
        points_sent++;
        gap = 0;
        if (!calm_source) begin
            r = $urandom_range(0, 99);
            if (r >= 92) begin
                gap = $urandom_range(8, 30);
            end else if (r >= 60) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic load_settings(input t_cfg c);
        logic [31:0] junk;
        int          i;
        junk = $urandom();
        write_reg(REG_MODE, {junk[31:4], c.mode});
        for (i = 0; i < 3; i++) begin
            write_reg(3'(REG_OFF_X + i), c.offset[i]);
            write_reg(3'(REG_SCL_X + i), {junk[i], c.scale[i]});
        end
        write_reg(REG_CCOL, c.const_colour);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic void add_write(input logic [2:0] idx, input logic [31:0] data);
        t_row r;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.data     = data;
        r.pt       = '0;
        r.fixed    = 1'b0;
        r.want     = '0;
        script.insert(script.size(), r);
    endfunction

    function automatic void add_point(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [31:0] col,
                                      input logic last);
        t_row r;
        r.is_write = 1'b0;
        r.idx      = '0;
        r.data     = '0;
        r.pt       = {x, y, z, col, last};
        r.fixed    = 1'b0;
        r.want     = '0;
        script.insert(script.size(), r);
    endfunction

    function automatic void add_known(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [31:0] col,
                                      input logic [31:0] ox, input logic [31:0] oy,
                                      input logic [31:0] oz, input logic [31:0] rgba);
        t_row r;
        r.is_write = 1'b0;
        r.idx      = '0;
        r.data     = '0;
        r.pt       = {x, y, z, col, 1'b0};
        r.fixed    = 1'b1;
        r.want     = '0;
        r.want.kind  = KIND_POINT;
        r.want.out_x = ox;
        r.want.out_y = oy;
        r.want.out_z = oz;
        {r.want.alpha, r.want.blue, r.want.green, r.want.red} = rgba;
        r.want.run_end = 1'b1;
        script.insert(script.size(), r);
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 7)) inside
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        t_cfg c;
        t_in  p;
        int   i;
        int   k;
        int   ph;
        int   n;

        cfg_mode   = '0;
        cfg_colour = 32'hFFFF_FFFF;
        for (i = 0; i < 3; i++) begin
            cfg_offset[i] = '0;
            cfg_scale[i]  = SCALE_RESET;
            box_lo[i]     = BOX_MIN_INIT;
            box_hi[i]     = BOX_MAX_INIT;
        end

        add_write(REG_MODE, {29'd0, COL_RGBA});
        add_known(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        add_known(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h4433_2211, 1'b1);
        add_write(REG_MODE, {29'd0, COL_RGB});
        add_known(32'd1, 32'd2, 32'd3, 32'hAB12_3456, 32'd1, 32'd2, 32'd3, 32'hFF12_3456);
        add_write(REG_MODE, {29'd0, COL_565});
        add_known(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        add_known(32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'hFF00_0000);
        add_known(32'h0, 32'h0, 32'h0, 32'h0000_F800, 32'h0, 32'h0, 32'h0, 32'hFF00_00FF);
        add_known(32'h0, 32'h0, 32'h0, 32'h0000_07E0, 32'h0, 32'h0, 32'h0, 32'hFF00_FF00);
        add_known(32'h0, 32'h0, 32'h0, 32'h0000_001F, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000);
        add_point(32'h0, 32'h0, 32'h0, 32'h0000_8410, 1'b0);
        add_write(REG_MODE, {29'd0, COL_CONST});
        add_known(32'h0, 32'h0, 32'h0, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        add_write(REG_CCOL, 32'h8040_2010);
        add_known(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8040_2010);
        add_write(REG_MODE, {29'd0, COL_WHITE});
        add_known(32'h0, 32'h0, 32'h0, 32'h55AA_55AA, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        add_write(REG_MODE, {29'd0, COL_WHITE_TOP});
        add_point(32'd5, 32'd6, 32'd7, 32'h0, 1'b1);
        add_write(REG_MODE, {28'd0, QUANT_FLAG | {1'b0, COL_RGBA}});
        add_known(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        add_known(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h0,
                  32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0);
        add_point(32'hFFFF_0000, 32'h7FFF_0001, 32'h8000_8000, 32'h0, 1'b0);
        add_write(REG_SCL_X, 32'd1);
        add_point(32'h7FFF, 32'h0, 32'h0, 32'h0, 1'b0);
        add_point(32'h8000, 32'h0, 32'h0, 32'h0, 1'b0);
        add_write(REG_OFF_Y, 32'h7FFF_FFFF);
        add_point(32'h0, 32'hFFFF, 32'h0, 32'h0, 1'b0);
        add_write(REG_OFF_Z, 32'h8000_0000);
        add_write(REG_SCL_Z, 32'h7FFF_FFFF);
        add_point(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h1234_5678, 1'b1);

        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        for (k = 0; k < script.size(); k++) begin
            if (script[k].is_write) begin
                drain();
                write_reg(script[k].idx, script[k].data);
                i_cfg_valid <= 1'b0;
            end else begin
                offer_point(script[k].pt, script[k].fixed, script[k].want);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    c.mode         = 4'hF;
                    c.offset       = {3{32'h7FFF_FFFF}};
                    c.scale        = {3{31'h7FFF_FFFF}};
                    c.const_colour = 32'hFFFF_FFFF;
                end
                1: begin
                    c.mode         = QUANT_FLAG | {1'b0, COL_RGBA};
                    c.offset       = {3{32'h8000_0000}};
                    c.scale        = '0;
                    c.const_colour = '0;
                end
                default: begin
                    c.mode         = 4'($urandom_range(0, 15));
                    c.const_colour = $urandom();
                    for (i = 0; i < 3; i++) begin
                        case ($urandom_range(0, 3))
                            0: c.offset[i] = $urandom();
                            1: c.offset[i] = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
                            2: c.offset[i] = 32'h7FFF_0000 + $urandom_range(0, 32'hFFFF);
                            default: c.offset[i] = 32'h8000_0000 + $urandom_range(0, 32'hFFFF);
                        endcase
                        case ($urandom_range(0, 3))
                            0: c.scale[i] = SCALE_RESET;
                            1: c.scale[i] = 31'($urandom_range(0, 32'h0004_0000));
                            2: c.scale[i] = 31'($urandom());
                            default: c.scale[i] = 31'(32'h7FFF_FFFF - $urandom_range(0, 255));
                        endcase
                    end
                end
            endcase

            drain();
            load_settings(c);
            calm_source = (ph % 4 == 3) || (ph == 2);
            calm_sink   = (ph % 4 == 3);
            if (ph == 2) hold_off_req = 1'b1;

            for (n = 0; n < POINTS_PER_PHASE; n++) begin
                p.coord_x = random_coord();
                p.coord_y = random_coord();
                p.coord_z = random_coord();
                case ($urandom_range(0, 9))
                    0:       p.colour_word = '0;
                    1:       p.colour_word = 32'hFFFF_FFFF;
                    default: p.colour_word = $urandom();
                endcase
                p.last_point = ($urandom_range(0, 9) == 0);
                offer_point(p, 1'b0, '0);
            end
        end

        drain();
        $display("%0d points sent through a directed script and %0d random register settings",
                 points_sent, settings_used);
        $display("%0d results compared field by field, %0d mismatches",
                 results_seen, errors);
        if (errors == 0) begin
            $display("point_cloud_attribute_decoder_core_tb: clean");
        end else begin
            $display("point_cloud_attribute_decoder_core_tb: errors");
        end
        $finish;
    end

endmodule
